### hw/rtl/pct_pkg.sv
// Shared types and codes for the palette color table.
// Holds the token control flags that travel along the cell chain.
// No dependencies.
package pct_pkg;

	localparam int unsigned COLOR_W = 15;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned COUNT_W = 9;

	localparam logic [COLOR_W-1:0] BLACK_BGR555 = 15'h0000;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Flags of one beat travelling down the chain
	typedef struct packed {
		logic valid;   // slot carries a beat
		logic insert;  // beat asks for the color to be appended if absent
		logic found;   // an occupied cell upstream held the color
		logic placed;  // an empty cell upstream took the color
	} tok_ctrl_t;

endpackage

### hw/rtl/pct_cell.sv
// One palette cell: stores one entry and compares or claims it for each passing beat.
// Depends on pct_pkg.
module pct_cell #(
	parameter int unsigned IDX         = 0,
	parameter int unsigned IDX_W       = 8,
	parameter int unsigned CNT_W       = 9,
	parameter bit          RESET_VALID = 1'b0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  pct_pkg::tok_ctrl_t          in_ctrl,
	input  logic [pct_pkg::COLOR_W-1:0] in_color,
	input  logic [IDX_W-1:0]            in_pos,
	input  logic [CNT_W-1:0]            in_count,
	output pct_pkg::tok_ctrl_t          out_ctrl,
	output logic [pct_pkg::COLOR_W-1:0] out_color,
	output logic [IDX_W-1:0]            out_pos,
	output logic [CNT_W-1:0]            out_count
);

	logic                        entry_valid_q;
	logic [pct_pkg::COLOR_W-1:0] entry_q;

	pct_pkg::tok_ctrl_t          ctrl_q;
	logic [pct_pkg::COLOR_W-1:0] color_q;
	logic [IDX_W-1:0]            pos_q;
	logic [CNT_W-1:0]            count_q;

	logic               hit;
	logic               claim;
	pct_pkg::tok_ctrl_t ctrl_d;
	logic [IDX_W-1:0]   pos_d;
	logic [CNT_W-1:0]   count_d;

	always_comb begin
		hit   = in_ctrl.valid && entry_valid_q && !in_ctrl.found && (in_color == entry_q);
		claim = in_ctrl.valid && !entry_valid_q && in_ctrl.insert &&
			!in_ctrl.found && !in_ctrl.placed;
		ctrl_d        = in_ctrl;
		ctrl_d.found  = in_ctrl.found | hit;
		ctrl_d.placed = in_ctrl.placed | claim;
		pos_d   = (hit || claim) ? IDX_W'(IDX) : in_pos;
		count_d = in_count + CNT_W'(entry_valid_q || claim);
	end

	// Entry state: fill once, in order along the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= RESET_VALID;
			entry_q       <= pct_pkg::BLACK_BGR555;
		end else if (advance && claim) begin
			entry_valid_q <= 1'b1;
			entry_q       <= in_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (advance) begin
			ctrl_q <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			color_q <= in_color;
			pos_q   <= pos_d;
			count_q <= count_d;
		end
	end

	assign out_ctrl  = ctrl_q;
	assign out_color = color_q;
	assign out_pos   = pos_q;
	assign out_count = count_q;

endmodule

### hw/rtl/palette_color_table.sv
// Palette color table: ordered BGR555 palette built as a systolic chain of cells.
// Depends on pct_pkg and pct_cell.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   in      | sink      | in_valid / in_ready | op, color
//   out     | source    | out_valid/out_ready | index, found, full_drop, entry_count
//
// Each cell registers a beat before passing it on, so a beat leaves from the tail after walking
// the whole chain; throughput is one beat per cycle while the output does not stall.
// Reset leaves cell 0 holding black and every other cell empty; no clearing pass.
// A stall on the output freezes the whole chain, so in_ready follows out_ready whenever
// the tail slot holds a beat.
module palette_color_table #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [pct_pkg::COLOR_W-1:0] color,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pct_pkg::INDEX_W-1:0] index,
	output logic                        found,
	output logic                        full_drop,
	output logic [pct_pkg::COUNT_W-1:0] entry_count
);

	localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);

	// Chain links: link k feeds cell k, link PALETTE_DEPTH is the tail
	pct_pkg::tok_ctrl_t          link_ctrl  [PALETTE_DEPTH+1];
	logic [pct_pkg::COLOR_W-1:0] link_color [PALETTE_DEPTH+1];
	logic [IDX_W-1:0]            link_pos   [PALETTE_DEPTH+1];
	logic [CNT_W-1:0]            link_count [PALETTE_DEPTH+1];

	pct_pkg::tok_ctrl_t          launch_ctrl;

	logic advance;

	// Advance the whole chain unless a finished beat waits at the tail
	assign advance  = !link_ctrl[PALETTE_DEPTH].valid || out_ready;
	assign in_ready = advance;

	// Launch a fresh beat, or a bubble when nothing is offered
	always_comb begin
		launch_ctrl.valid  = in_valid;
		launch_ctrl.insert = (op == pct_pkg::OP_INSERT);
		launch_ctrl.found  = 1'b0;
		launch_ctrl.placed = 1'b0;
	end
	assign link_ctrl[0]  = launch_ctrl;
	assign link_color[0] = color;
	assign link_pos[0]   = '0;
	assign link_count[0] = '0;

	for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
		pct_cell #(
			.IDX         (k),
			.IDX_W       (IDX_W),
			.CNT_W       (CNT_W),
			.RESET_VALID (k == 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_ctrl   (link_ctrl[k]),
			.in_color  (link_color[k]),
			.in_pos    (link_pos[k]),
			.in_count  (link_count[k]),
			.out_ctrl  (link_ctrl[k+1]),
			.out_color (link_color[k+1]),
			.out_pos   (link_pos[k+1]),
			.out_count (link_count[k+1])
		);
	end

	// Tail: a beat that neither matched nor claimed a cell on insert was dropped.
	// Its position stayed at zero, as did that of a lookup miss.
	logic [IDX_W+pct_pkg::INDEX_W-1:0] pos_ext;
	logic [CNT_W+pct_pkg::COUNT_W-1:0] count_ext;

	assign pos_ext   = {{pct_pkg::INDEX_W{1'b0}}, link_pos[PALETTE_DEPTH]};
	assign count_ext = {{pct_pkg::COUNT_W{1'b0}}, link_count[PALETTE_DEPTH]};

	assign out_valid   = link_ctrl[PALETTE_DEPTH].valid;
	assign index       = pos_ext[pct_pkg::INDEX_W-1:0];
	assign found       = link_ctrl[PALETTE_DEPTH].found;
	assign full_drop   = link_ctrl[PALETTE_DEPTH].insert && !link_ctrl[PALETTE_DEPTH].found &&
		!link_ctrl[PALETTE_DEPTH].placed;
	assign entry_count = count_ext[pct_pkg::COUNT_W-1:0];

endmodule
